FILE: rtl/lfmc_pkg.sv
package lfmc_pkg;

   // Control modes
   typedef enum logic [2:0] {
      MODE_FOLLOW   = 3'd0,
      MODE_CROSS    = 3'd1,
      MODE_SHARP_L  = 3'd2,
      MODE_SHARP_R  = 3'd3,
      MODE_SEARCH_L = 3'd4,
      MODE_SEARCH_R = 3'd5
   } mode_type;

   // Motor commands
   typedef enum logic [2:0] {
      CMD_FORWARD = 3'd0,
      CMD_TURN_L  = 3'd1,
      CMD_TURN_R  = 3'd2,
      CMD_SPIN_L  = 3'd3,
      CMD_SPIN_R  = 3'd4
   } cmd_type;

   // Register indexes of the control/status port
   typedef enum logic [2:0] {
      REG_CRUISE_SPEED   = 3'd0,
      REG_INNER_SPEED    = 3'd1,
      REG_TURN_GAIN      = 3'd2,
      REG_DIFF_LIMIT     = 3'd3,
      REG_PWM_FLOOR      = 3'd4,
      REG_PWM_CEILING    = 3'd5,
      REG_LOST_HOLD      = 3'd6,
      REG_SEARCH_TIMEOUT = 3'd7
   } reg_index_type;

   localparam int unsigned SENSOR_W  = 4;
   localparam int unsigned PWM_W     = 10;
   localparam int unsigned GAIN_W    = 8;
   localparam int unsigned LOST_W    = 4;
   localparam int unsigned TICK_W    = 6;
   localparam int unsigned ERR_W     = 3;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DAT_W = 10;
   localparam int unsigned REQ_DAT_W = 8;
   localparam int unsigned RSP_DAT_W = 40;

   localparam logic [PWM_W-1:0]  CROSS_PWM  = 10'd170;
   localparam logic [PWM_W-1:0]  SHARP_PWM  = 10'd160;
   localparam logic [PWM_W-1:0]  SEARCH_PWM = 10'd210;
   localparam logic [TICK_W-1:0] CROSS_HOLD = 6'd8;
   localparam logic [TICK_W-1:0] SHARP_HOLD = 6'd2;
   localparam logic [TICK_W-1:0] TICK_MAX   = 6'd63;
   localparam logic [LOST_W-1:0] LOST_MAX   = 4'd15;

   // Register reset values
   localparam logic [PWM_W-1:0]  CRUISE_SPEED_RST   = 10'd230;
   localparam logic [PWM_W-1:0]  INNER_SPEED_RST    = 10'd190;
   localparam logic [GAIN_W-1:0] TURN_GAIN_RST      = 8'd85;
   localparam logic [PWM_W-1:0]  DIFF_LIMIT_RST     = 10'd170;
   localparam logic [PWM_W-1:0]  PWM_FLOOR_RST      = 10'd100;
   localparam logic [PWM_W-1:0]  PWM_CEILING_RST    = 10'd360;
   localparam logic [LOST_W-1:0] LOST_HOLD_RST      = 4'd10;
   localparam logic [TICK_W-1:0] SEARCH_TIMEOUT_RST = 6'd30;

   typedef struct packed {
      logic [PWM_W-1:0]  cruise_speed;
      logic [PWM_W-1:0]  inner_speed;
      logic [GAIN_W-1:0] turn_gain;
      logic [PWM_W-1:0]  diff_limit;
      logic [PWM_W-1:0]  pwm_floor;
      logic [PWM_W-1:0]  pwm_ceiling;
      logic [LOST_W-1:0] lost_hold_ticks;
      logic [TICK_W-1:0] search_timeout_ticks;
   } cfg_type;

   // Mode decision handed to the PWM stage
   typedef struct packed {
      mode_type                 mode;
      logic signed [ERR_W-1:0]  err;
      logic [SENSOR_W-1:0]      sensor_bits;
   } decision_type;

   // Result payload, first field in the highest bits
   typedef struct packed {
      logic [2:0]       current_mode;
      logic [PWM_W-1:0] wheel_r_pwm;
      logic [PWM_W-1:0] wheel_l_pwm;
      logic [PWM_W-1:0] common_pwm;
      logic [2:0]       motor_command;
   } result_type;

   // Sensor pattern to line error
   function automatic logic signed [ERR_W-1:0] err_lookup(input logic [SENSOR_W-1:0] s);
      logic signed [ERR_W-1:0] e;
      case (s)
         4'h1, 4'h3: e = -3'sd2;
         4'h2:       e = -3'sd1;
         4'h4:       e = 3'sd1;
         4'h8, 4'hC: e = 3'sd2;
         4'hB:       e = 3'sd3;
         4'hD, 4'hE: e = -3'sd3;
         default:    e = 3'sd0;
      endcase
      return e;
   endfunction

endpackage

FILE: rtl/lfmc_csr.sv
module lfmc_csr
   import lfmc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Decode the write transaction
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (reg_index_type'(csr_index))
            REG_CRUISE_SPEED:   cfg_in.cruise_speed         = csr_data[PWM_W-1:0];
            REG_INNER_SPEED:    cfg_in.inner_speed          = csr_data[PWM_W-1:0];
            REG_TURN_GAIN:      cfg_in.turn_gain            = csr_data[GAIN_W-1:0];
            REG_DIFF_LIMIT:     cfg_in.diff_limit           = csr_data[PWM_W-1:0];
            REG_PWM_FLOOR:      cfg_in.pwm_floor            = csr_data[PWM_W-1:0];
            REG_PWM_CEILING:    cfg_in.pwm_ceiling          = csr_data[PWM_W-1:0];
            REG_LOST_HOLD:      cfg_in.lost_hold_ticks      = csr_data[LOST_W-1:0];
            REG_SEARCH_TIMEOUT: cfg_in.search_timeout_ticks = csr_data[TICK_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cruise_speed         <= CRUISE_SPEED_RST;
         cfg_ff.inner_speed          <= INNER_SPEED_RST;
         cfg_ff.turn_gain            <= TURN_GAIN_RST;
         cfg_ff.diff_limit           <= DIFF_LIMIT_RST;
         cfg_ff.pwm_floor            <= PWM_FLOOR_RST;
         cfg_ff.pwm_ceiling          <= PWM_CEILING_RST;
         cfg_ff.lost_hold_ticks      <= LOST_HOLD_RST;
         cfg_ff.search_timeout_ticks <= SEARCH_TIMEOUT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: rtl/lfmc_mode_ctrl.sv
module lfmc_mode_ctrl
   import lfmc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic [SENSOR_W-1:0] sensor_bits,
   input  cfg_type             cfg,
   output decision_type        decision
);

   logic signed [ERR_W-1:0] last_error_ff, last_error_in;
   mode_type                mode_ff, mode_in;
   logic [TICK_W-1:0]       ticks_ff, ticks_in;
   logic [LOST_W-1:0]       lost_ff, lost_in;

   logic signed [ERR_W-1:0] err;
   logic                    usable, centered, crossing;
   mode_type                lost_dir, mode_mid;
   logic [TICK_W-1:0]       ticks_mid, ticks_end;
   logic [LOST_W-1:0]       lost_inc;
   logic                    timed_out;

   // Classify the sample and pick the error
   always_comb begin
      err      = (sensor_bits == 4'h0) ? last_error_ff : err_lookup(sensor_bits);
      usable   = (sensor_bits != 4'h0) && (sensor_bits != 4'hF);
      centered = (sensor_bits == 4'h6) || (sensor_bits == 4'h9) ||
                 (sensor_bits == 4'h5) || (sensor_bits == 4'hA);
      crossing = (sensor_bits == 4'hF) || (sensor_bits == 4'h9);
      last_error_in = (usable && (err != 3'sd0)) ? err : last_error_ff;
      lost_dir      = last_error_in[ERR_W-1] ? MODE_SEARCH_L : MODE_SEARCH_R;
      timed_out     = (ticks_ff >= cfg.search_timeout_ticks);
   end

   // Exit checks of the special modes
   always_comb begin
      mode_mid = mode_ff;
      unique case (mode_ff)
         MODE_CROSS: begin
            if ((ticks_ff >= CROSS_HOLD) && usable && centered) begin
               mode_mid = MODE_FOLLOW;
            end else if (timed_out && (sensor_bits == 4'h0)) begin
               mode_mid = lost_dir;
            end
         end
         MODE_SHARP_L: begin
            if (usable && (centered || ((ticks_ff >= SHARP_HOLD) && (err >= -3'sd1)))) begin
               mode_mid = MODE_FOLLOW;
            end else if (timed_out && (sensor_bits == 4'h0)) begin
               mode_mid = MODE_SEARCH_L;
            end
         end
         MODE_SHARP_R: begin
            if (usable && (centered || ((ticks_ff >= SHARP_HOLD) && (err <= 3'sd1)))) begin
               mode_mid = MODE_FOLLOW;
            end else if (timed_out && (sensor_bits == 4'h0)) begin
               mode_mid = MODE_SEARCH_R;
            end
         end
         MODE_SEARCH_L, MODE_SEARCH_R: begin
            if (usable || crossing) begin
               mode_mid = MODE_FOLLOW;
            end else if (timed_out) begin
               mode_mid = (mode_ff == MODE_SEARCH_L) ? MODE_SEARCH_R : MODE_SEARCH_L;
            end
         end
         default: mode_mid = mode_ff;
      endcase
      ticks_mid = (mode_mid != mode_ff) ? '0 : ticks_ff;
   end

   // Follow-mode entry checks and lost-line counting
   always_comb begin
      mode_in  = mode_mid;
      lost_in  = lost_ff;
      lost_inc = (lost_ff < LOST_MAX) ? lost_ff + 4'd1 : lost_ff;
      if (mode_mid == MODE_FOLLOW) begin
         if (crossing) begin
            mode_in = MODE_CROSS;
            lost_in = '0;
         end else if ((err <= -3'sd1) && ((sensor_bits == 4'h3) ||
                      (sensor_bits == 4'hD) || (sensor_bits == 4'hE))) begin
            mode_in = MODE_SHARP_L;
            lost_in = '0;
         end else if ((err >= 3'sd1) && ((sensor_bits == 4'hB) || (sensor_bits == 4'hC))) begin
            mode_in = MODE_SHARP_R;
            lost_in = '0;
         end else if (sensor_bits == 4'h0) begin
            if (lost_inc >= cfg.lost_hold_ticks) begin
               lost_in = '0;
               mode_in = lost_dir;
            end else begin
               lost_in = lost_inc;
            end
         end else begin
            lost_in = '0;
         end
      end
      ticks_end = (mode_in != mode_mid) ? '0 : ticks_mid;
      ticks_in  = (ticks_end < TICK_MAX) ? ticks_end + 6'd1 : ticks_end;
   end

   assign decision.mode        = mode_in;
   assign decision.err         = err;
   assign decision.sensor_bits = sensor_bits;

   // Hold state; advance once per transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         last_error_ff <= '0;
         mode_ff       <= MODE_FOLLOW;
         ticks_ff      <= '0;
         lost_ff       <= '0;
      end else if (advance) begin
         last_error_ff <= last_error_in;
         mode_ff       <= mode_in;
         ticks_ff      <= ticks_in;
         lost_ff       <= lost_in;
      end
   end

endmodule

FILE: rtl/lfmc_pwm_calc.sv
module lfmc_pwm_calc
   import lfmc_pkg::*;
(
   input  decision_type decision,
   input  cfg_type      cfg,
   output result_type   result
);

   logic [PWM_W-1:0]  base;
   logic signed [11:0] err_x, gain_x, turn_raw, turn, lim;
   logic signed [12:0] sum_l, sum_r, floor_x, ceil_x;
   logic [PWM_W-1:0]  follow_l, follow_r;

   // Follow-mode differential drive
   always_comb begin
      base   = ((decision.sensor_bits == 4'h2) || (decision.sensor_bits == 4'h4)) ?
               cfg.inner_speed : cfg.cruise_speed;
      err_x  = 12'(decision.err);
      gain_x = $signed({4'b0, cfg.turn_gain});
      lim    = $signed({2'b0, cfg.diff_limit});
      turn_raw = err_x * gain_x;
      if (turn_raw > lim) begin
         turn = lim;
      end else if (turn_raw < -lim) begin
         turn = -lim;
      end else begin
         turn = turn_raw;
      end
      sum_l   = $signed({3'b0, base}) + 13'(turn);
      sum_r   = $signed({3'b0, base}) - 13'(turn);
      floor_x = $signed({3'b0, cfg.pwm_floor});
      ceil_x  = $signed({3'b0, cfg.pwm_ceiling});
      if (sum_l < floor_x)      follow_l = cfg.pwm_floor;
      else if (sum_l > ceil_x)  follow_l = cfg.pwm_ceiling;
      else                      follow_l = sum_l[PWM_W-1:0];
      if (sum_r < floor_x)      follow_r = cfg.pwm_floor;
      else if (sum_r > ceil_x)  follow_r = cfg.pwm_ceiling;
      else                      follow_r = sum_r[PWM_W-1:0];
   end

   // Drive the motor command for the mode
   always_comb begin
      result.current_mode  = decision.mode;
      result.motor_command = CMD_FORWARD;
      result.common_pwm    = '0;
      result.wheel_l_pwm   = follow_l;
      result.wheel_r_pwm   = follow_r;
      unique case (decision.mode)
         MODE_CROSS: begin
            result.wheel_l_pwm = CROSS_PWM;
            result.wheel_r_pwm = CROSS_PWM;
         end
         MODE_SHARP_L: begin
            result.motor_command = CMD_TURN_L;
            result.common_pwm    = SHARP_PWM;
            result.wheel_l_pwm   = SHARP_PWM >> 1;
            result.wheel_r_pwm   = SHARP_PWM;
         end
         MODE_SHARP_R: begin
            result.motor_command = CMD_TURN_R;
            result.common_pwm    = SHARP_PWM;
            result.wheel_l_pwm   = SHARP_PWM;
            result.wheel_r_pwm   = SHARP_PWM >> 1;
         end
         MODE_SEARCH_L: begin
            result.motor_command = CMD_SPIN_L;
            result.common_pwm    = SEARCH_PWM;
            result.wheel_l_pwm   = SEARCH_PWM;
            result.wheel_r_pwm   = SEARCH_PWM;
         end
         MODE_SEARCH_R: begin
            result.motor_command = CMD_SPIN_R;
            result.common_pwm    = SEARCH_PWM;
            result.wheel_l_pwm   = SEARCH_PWM;
            result.wheel_r_pwm   = SEARCH_PWM;
         end
         default: begin
            result.wheel_l_pwm = follow_l;
            result.wheel_r_pwm = follow_r;
         end
      endcase
   end

endmodule

FILE: rtl/line_follow_mode_controller_core.sv
// Channel   Direction  Handshake              Payload
// req_      in         req_tvalid/req_tready  tdata[3:0] sensor_bits
// rsp_      out        rsp_tvalid/rsp_tready  tdata[35:0] command, pwms, mode
// csr_      in         csr_valid/csr_ready    csr_index, csr_data
//
// One sample enters per cycle while the result register is not stalled; it goes from
// the input register through mode and PWM logic into the result register.
// Mode, tick and lost-line state update as a sample moves into the result register.
// A stalled result holds both registers; the input side still takes one sample.
// Reset is synchronous and restores the follow mode and register defaults.
module line_follow_mode_controller_core
   import lfmc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [REQ_DAT_W-1:0] req_tdata,  // [3:0] sensor_bits
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [RSP_DAT_W-1:0] rsp_tdata,  // [2:0] motor_command, [12:3] common_pwm,
                                            // [22:13] wheel_l_pwm, [32:23] wheel_r_pwm,
                                            // [35:33] current_mode
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data
);

   logic                in_valid_ff, in_valid_in;
   logic [SENSOR_W-1:0] in_sensor_ff;
   logic                out_valid_ff, out_valid_in;
   result_type          out_result_ff;

   logic         out_free;
   logic         advance;
   cfg_type      cfg;
   decision_type decision;
   result_type   result;

   // Move a sample forward when the result register can take it
   assign out_free     = !out_valid_ff || rsp_tready;
   assign advance      = in_valid_ff && out_free;
   assign req_tready   = !in_valid_ff || advance;
   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(RSP_DAT_W - $bits(result_type))'(0), out_result_ff};

   lfmc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   lfmc_mode_ctrl u_mode_ctrl (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .sensor_bits (in_sensor_ff),
      .cfg         (cfg),
      .decision    (decision)
   );

   lfmc_pwm_calc u_pwm_calc (
      .decision (decision),
      .cfg      (cfg),
      .result   (result)
   );

   // Handshake state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_sensor_ff <= req_tdata[SENSOR_W-1:0];
      end
      if (advance) begin
         out_result_ff <= result;
      end
   end

endmodule
